/* sv/rld_pkg.sv */
package rld_pkg;

  localparam int COORD_BITS = 16;
  localparam int OUT_BITS   = COORD_BITS + 4;
  localparam int COEF_BITS  = 16;
  localparam int COEF_FRAC  = 12;

  // register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_K1     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_K2     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZOOM_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZOOM_Y = 2'd3;

  localparam logic [COEF_BITS-1:0] ZOOM_ONE = COEF_BITS'(1) << COEF_FRAC;

  // coefficient products and the radial factor
  localparam int K_PROD_W = COEF_BITS + COORD_BITS + 1;
  localparam int P_BITS   = K_PROD_W + 1;
  localparam int PF_BITS  = P_BITS - COEF_FRAC;

  typedef logic signed [COORD_BITS-1:0] delta_t;
  typedef logic [COORD_BITS-1:0]        frac_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic [COEF_BITS-1:0]         zoom_t;
  typedef logic signed [PF_BITS-1:0]    factor_val_t;

  typedef struct packed {
    delta_t dx;
    delta_t dy;
    frac_t  r2f;
  } radius_t;

  typedef struct packed {
    delta_t      dx;
    delta_t      dy;
    factor_val_t pf;
  } factor_t;

endpackage

/* sv/rld_radius.sv */
module rld_radius
  import rld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  frac_t   coord_u,
  input  frac_t   coord_v,
  output logic    out_valid,
  input  logic    out_stall,
  output radius_t out_data
);

  localparam int NS = 2;
  localparam int SQ_W = 2 * COORD_BITS;
  localparam logic [SQ_W-1:0] RND_SQ = SQ_W'(1) << (COORD_BITS - 1);

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  delta_t dx_next;
  delta_t dy_next;
  logic signed [SQ_W-1:0] dxx_next;
  logic signed [SQ_W-1:0] dyy_next;

  delta_t dx1;
  delta_t dy1;
  logic signed [SQ_W-1:0] dxx1;
  logic signed [SQ_W-1:0] dyy1;

  logic [SQ_W-1:0] r2sum;
  radius_t         res;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // offset from centre: flip the top bit
  assign dx_next  = {~coord_u[COORD_BITS-1], coord_u[COORD_BITS-2:0]};
  assign dy_next  = {~coord_v[COORD_BITS-1], coord_v[COORD_BITS-2:0]};
  assign dxx_next = dx_next * dx_next;
  assign dyy_next = dy_next * dy_next;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx1  <= dx_next;
      dy1  <= dy_next;
      dxx1 <= dxx_next;
      dyy1 <= dyy_next;
    end
  end

  assign r2sum = $unsigned(dxx1) + $unsigned(dyy1) + RND_SQ;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      res.dx  <= dx1;
      res.dy  <= dy1;
      res.r2f <= r2sum[SQ_W-1:COORD_BITS];
    end
  end

  assign out_data = res;

endmodule

/* sv/rld_poly.sv */
module rld_poly
  import rld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  radius_t in_data,
  input  coef_t   coef_k1,
  input  coef_t   coef_k2,
  output logic    out_valid,
  input  logic    out_stall,
  output factor_t out_data
);

  localparam int NS = 3;
  localparam int SQ_W = 2 * COORD_BITS;
  localparam logic [SQ_W-1:0]   RND_SQ  = SQ_W'(1) << (COORD_BITS - 1);
  localparam logic [P_BITS-1:0] P_ONE   = P_BITS'(1) << (COORD_BITS + COEF_FRAC);
  localparam logic [P_BITS-1:0] RND_CF  = P_BITS'(1) << (COEF_FRAC - 1);

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  logic [SQ_W-1:0]               sq_next;
  logic signed [K_PROD_W-1:0]    k1t_next;
  delta_t                        dx3;
  delta_t                        dy3;
  logic [SQ_W-1:0]               sq3;
  logic signed [K_PROD_W-1:0]    k1t3;

  logic [SQ_W-1:0]               r4sum;
  frac_t                         r4;
  logic signed [K_PROD_W-1:0]    k2t_next;
  delta_t                        dx4;
  delta_t                        dy4;
  logic signed [K_PROD_W-1:0]    k1t4;
  logic signed [K_PROD_W-1:0]    k2t4;

  logic [P_BITS-1:0]             psum;
  factor_t                       res;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign sq_next  = in_data.r2f * in_data.r2f;
  assign k1t_next = coef_k1 * $signed({1'b0, in_data.r2f});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx3  <= in_data.dx;
      dy3  <= in_data.dy;
      sq3  <= sq_next;
      k1t3 <= k1t_next;
    end
  end

  assign r4sum    = sq3 + RND_SQ;
  assign r4       = r4sum[SQ_W-1:COORD_BITS];
  assign k2t_next = coef_k2 * $signed({1'b0, r4});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dx4  <= dx3;
      dy4  <= dy3;
      k1t4 <= k1t3;
      k2t4 <= k2t_next;
    end
  end

  assign psum = {{(P_BITS-K_PROD_W){k1t4[K_PROD_W-1]}}, k1t4}
              + {{(P_BITS-K_PROD_W){k2t4[K_PROD_W-1]}}, k2t4}
              + P_ONE + RND_CF;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      res.dx <= dx4;
      res.dy <= dy4;
      res.pf <= psum[P_BITS-1:COEF_FRAC];
    end
  end

  assign out_data = res;

endmodule

/* sv/rld_scale.sv */
module rld_scale
  import rld_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  factor_t                     in_data,
  input  zoom_t                       zoom_x,
  input  zoom_t                       zoom_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_BITS-1:0]  src_x,
  output logic signed [OUT_BITS-1:0]  src_y
);

  localparam int NS     = 3;
  localparam int DP_W   = COORD_BITS + PF_BITS;
  localparam int T_BITS = DP_W - COORD_BITS;
  localparam int ZP_W   = T_BITS + COEF_BITS + 1;
  localparam int S_BITS = ZP_W - COEF_FRAC;
  localparam int R_W    = S_BITS + 1;

  localparam logic [DP_W-1:0] RND_T = DP_W'(1) << (COORD_BITS - 1);
  localparam logic [ZP_W-1:0] RND_Z = ZP_W'(1) << (COEF_FRAC - 1);
  localparam logic [R_W-1:0]  HALF  = R_W'(1) << (COORD_BITS - 1);
  localparam logic signed [R_W-1:0] SAT_HI = R_W'((2 ** (OUT_BITS - 1)) - 1);
  localparam logic signed [R_W-1:0] SAT_LO = -SAT_HI - R_W'(1);

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  logic signed [DP_W-1:0]   tx_next;
  logic signed [DP_W-1:0]   ty_next;
  logic signed [DP_W-1:0]   tx6;
  logic signed [DP_W-1:0]   ty6;

  logic [DP_W-1:0]          txsum;
  logic [DP_W-1:0]          tysum;
  logic signed [T_BITS-1:0] tx;
  logic signed [T_BITS-1:0] ty;
  logic signed [ZP_W-1:0]   zx_next;
  logic signed [ZP_W-1:0]   zy_next;
  logic signed [ZP_W-1:0]   zx7;
  logic signed [ZP_W-1:0]   zy7;

  logic [ZP_W-1:0]          zxsum;
  logic [ZP_W-1:0]          zysum;
  logic [S_BITS-1:0]        sx;
  logic [S_BITS-1:0]        sy;
  logic signed [R_W-1:0]    rx;
  logic signed [R_W-1:0]    ry;
  logic signed [R_W-1:0]    cx;
  logic signed [R_W-1:0]    cy;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign tx_next = in_data.dx * in_data.pf;
  assign ty_next = in_data.dy * in_data.pf;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tx6 <= tx_next;
      ty6 <= ty_next;
    end
  end

  assign txsum   = tx6 + RND_T;
  assign tysum   = ty6 + RND_T;
  assign tx      = txsum[DP_W-1:COORD_BITS];
  assign ty      = tysum[DP_W-1:COORD_BITS];
  assign zx_next = tx * $signed({1'b0, zoom_x});
  assign zy_next = ty * $signed({1'b0, zoom_y});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      zx7 <= zx_next;
      zy7 <= zy_next;
    end
  end

  assign zxsum = zx7 + RND_Z;
  assign zysum = zy7 + RND_Z;
  assign sx    = zxsum[ZP_W-1:COEF_FRAC];
  assign sy    = zysum[ZP_W-1:COEF_FRAC];
  assign rx    = {sx[S_BITS-1], sx} + HALF;
  assign ry    = {sy[S_BITS-1], sy} + HALF;

  // clamp to the output range
  always_comb begin
    cx = rx;
    if (rx > SAT_HI) begin
      cx = SAT_HI;
    end else if (rx < SAT_LO) begin
      cx = SAT_LO;
    end
    cy = ry;
    if (ry > SAT_HI) begin
      cy = SAT_HI;
    end else if (ry < SAT_LO) begin
      cy = SAT_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      src_x <= cx[OUT_BITS-1:0];
      src_y <= cy[OUT_BITS-1:0];
    end
  end

endmodule

/* sv/radial_lens_distortion.sv */
// Radial lens distortion (k1/k2 radial terms) for one unsigned Q0.16 texture
// coordinate per transaction, giving a saturated signed Q4.16 source pair.
// The block is an eight-stage pipeline and takes one coordinate every clock
// while the output is not stalled; a result passes through the radius,
// polynomial and scale sections in order, and a held output stall backs the
// pipeline up stage by stage, empty stages filling first.
// Coefficients and zoom are written through the cfg port while no transaction
// is in flight; the user must keep to this, as the block does not enforce it.
module radial_lens_distortion
  import rld_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [COEF_BITS-1:0]        cfg_data,
  input  logic                        coord_valid,
  output logic                        coord_stall,
  input  logic [COORD_BITS-1:0]       coord_u,
  input  logic [COORD_BITS-1:0]       coord_v,
  output logic                        src_valid,
  input  logic                        src_stall,
  output logic signed [OUT_BITS-1:0]  src_x,
  output logic signed [OUT_BITS-1:0]  src_y
);

  coef_t coef_k1;
  coef_t coef_k2;
  zoom_t zoom_x;
  zoom_t zoom_y;

  logic    rad_valid;
  logic    rad_stall;
  radius_t rad_data;
  logic    fac_valid;
  logic    fac_stall;
  factor_t fac_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_k1 <= '0;
      coef_k2 <= '0;
      zoom_x  <= ZOOM_ONE;
      zoom_y  <= ZOOM_ONE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_K1:     coef_k1 <= cfg_data;
        REG_K2:     coef_k2 <= cfg_data;
        REG_ZOOM_X: zoom_x  <= cfg_data;
        REG_ZOOM_Y: zoom_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  rld_radius u_radius (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coord_valid),
    .in_stall  (coord_stall),
    .coord_u   (coord_u),
    .coord_v   (coord_v),
    .out_valid (rad_valid),
    .out_stall (rad_stall),
    .out_data  (rad_data)
  );

  rld_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rad_valid),
    .in_stall  (rad_stall),
    .in_data   (rad_data),
    .coef_k1   (coef_k1),
    .coef_k2   (coef_k2),
    .out_valid (fac_valid),
    .out_stall (fac_stall),
    .out_data  (fac_data)
  );

  rld_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fac_valid),
    .in_stall  (fac_stall),
    .in_data   (fac_data),
    .zoom_x    (zoom_x),
    .zoom_y    (zoom_y),
    .out_valid (src_valid),
    .out_stall (src_stall),
    .src_x     (src_x),
    .src_y     (src_y)
  );

endmodule
